FILE: hdl/i3c_master_register_frontend_assert.svh
// Assertion macros for the I3C master register front end.
`ifndef I3C_MASTER_REGISTER_FRONTEND_ASSERT_SVH
`define I3C_MASTER_REGISTER_FRONTEND_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define FE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/i3cm_fe_pkg.sv
// Types and constants of the I3C master register front end.
package i3cm_fe_pkg;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_BYTE  = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_SEND  = 2'd3
	} bus_cmd_t;

	// control register request field
	localparam logic [2:0] REQ_START  = 3'd1;
	localparam logic [2:0] REQ_STOP   = 3'd2;
	localparam logic [2:0] REQ_ASSIGN = 3'd4;

	// register byte offsets
	localparam logic [15:0] OFF_CTRL      = 16'h0084;
	localparam logic [15:0] OFF_STATUS    = 16'h0088;
	localparam logic [15:0] OFF_INTSET    = 16'h0090;
	localparam logic [15:0] OFF_INTCLR    = 16'h0094;
	localparam logic [15:0] OFF_INTMASKED = 16'h0098;
	localparam logic [15:0] OFF_ERR       = 16'h009c;
	localparam logic [15:0] OFF_DATACTRL  = 16'h00ac;
	localparam logic [15:0] OFF_TXB       = 16'h00b0;
	localparam logic [15:0] OFF_TXBE      = 16'h00b4;
	localparam logic [15:0] OFF_TXH       = 16'h00b8;
	localparam logic [15:0] OFF_TXHE      = 16'h00bc;
	localparam logic [15:0] OFF_RXB       = 16'h00c0;
	localparam logic [15:0] OFF_RXH       = 16'h00c8;

	localparam int ST_W  = 11;
	localparam int ERR_W = 3;

	localparam logic [ST_W-1:0]  ST_NACKED   = 11'h020;
	localparam logic [ST_W-1:0]  ST_CTRLDONE = 11'h200;
	localparam logic [ST_W-1:0]  ST_COMPLETE = 11'h400;
	localparam logic [ERR_W-1:0] ERR_NACK    = 3'b100;

	localparam logic [31:0] RD_RXPEND    = 32'h0000_0800;
	localparam logic [31:0] RD_TXNOTFULL = 32'h0000_1000;
	localparam logic [31:0] RD_ERRWARN   = 32'h0000_8000;
	localparam logic [31:0] RD_RXEMPTY   = 32'h8000_0000;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] offset;
		logic [31:0] write_data;
		logic        target_ack;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		bus_cmd_t    bus_cmd;
		logic        bus_is_i2c;
		logic [6:0]  bus_addr;
		logic        bus_read;
		logic [7:0]  bus_data;
		logic [7:0]  read_length;
	} result_t;

endpackage

FILE: hdl/i3c_master_register_frontend.sv
// Register front end of an I3C/I2C bus master: registers, status, irq and receive FIFO.
// One request per cycle unless the result stalls, each with one result: a request enters
// the input stage (where the scratch memory read lands) and its result is then registered
// in the result register. A stalled result holds the input stage, so item_stall follows
// result_stall in the same cycle. After reset the scratch memory is zeroed, one word per
// cycle; item_stall is high meanwhile.
`include "i3c_master_register_frontend_assert.svh"

module i3c_master_register_frontend
	import i3cm_fe_pkg::*;
#(
	parameter int RX_DEPTH  = 16,
	parameter int REG_WORDS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int CW  = $clog2(RX_DEPTH + 1);
	localparam int PIW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int AW  = $clog2(REG_WORDS);

	// scratch memory and its clearing pass
	logic [31:0]   mem [REG_WORDS];
	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          in_word_range;
	logic          in_special_wr;

	// pipeline
	item_t       item_s1;
	logic        valid_s1;
	logic [31:0] rdata_s1;
	logic        item_acc;
	logic        adv;
	result_t     result_q;
	logic        result_valid_q;

	// architectural state
	logic [ST_W-1:0]  status_q;
	logic [ERR_W-1:0] err_q;
	logic [31:0]      irq_en_q;
	logic [7:0]       fifo_q [RX_DEPTH];
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    pos_q;
	logic [7:0]       rem_q;
	logic             i2c_q;

	logic [ST_W-1:0]  status_n;
	logic [ERR_W-1:0] err_n;
	logic [31:0]      irq_en_n;
	logic [CW-1:0]    fill_n;
	logic [CW-1:0]    pos_n;
	logic [7:0]       rem_n;
	logic             i2c_n;
	logic             fifo_we;
	logic [PIW-1:0]   fifo_widx;
	result_t          res_n;

	assign adv        = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = clearing_q || (valid_s1 && !adv);
	assign item_acc   = item_valid && !item_stall;

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// Scratch writes depend only on the request, so they go in at accept time;
	// a later read then always sees them.
	assign in_word_range = {1'b0, item.offset[15:2]} < 15'(REG_WORDS);
	assign in_special_wr = item.offset == OFF_STATUS || item.offset == OFF_ERR ||
		item.offset == OFF_INTSET || item.offset == OFF_INTCLR ||
		item.offset == OFF_TXB || item.offset == OFF_TXBE ||
		item.offset == OFF_TXH || item.offset == OFF_TXHE;

	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_we    = item_acc && item.kind == KIND_WRITE && in_word_range && !in_special_wr;
			mem_waddr = item.offset[AW+1:2];
			mem_wdata = (item.offset == OFF_DATACTRL) ?
				(item.write_data & ~32'h3) : item.write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (item_acc) begin
			rdata_s1 <= mem[item.offset[AW+1:2]];
			item_s1  <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == AW'(REG_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		logic [31:0]  v;
		logic [7:0]   rdterm;
		logic [CW:0]  push_idx;
		logic         rd_word_ok;
		logic [31:0]  masked;

		v          = item_s1.write_data;
		rdterm     = v[23:16];
		push_idx   = {1'b0, pos_q} + {1'b0, fill_q};
		rd_word_ok = {1'b0, item_s1.offset[15:2]} < 15'(REG_WORDS);

		status_n  = status_q;
		err_n     = err_q;
		irq_en_n  = irq_en_q;
		fill_n    = fill_q;
		pos_n     = pos_q;
		rem_n     = rem_q;
		i2c_n     = i2c_q;
		fifo_we   = 1'b0;
		fifo_widx = push_idx[PIW-1:0];
		res_n     = '0;

		case (item_s1.kind)
			KIND_READ: begin
				if (item_s1.offset == OFF_STATUS) begin
					res_n.read_data = {21'b0, status_q} | RD_TXNOTFULL |
						((fill_q != '0) ? RD_RXPEND : 32'b0);
				end else if (item_s1.offset == OFF_ERR) begin
					res_n.read_data = {29'b0, err_q};
				end else if (item_s1.offset == OFF_INTMASKED) begin
					res_n.read_data = ({21'b0, status_q} |
						((err_q != '0) ? RD_ERRWARN : 32'b0)) & irq_en_q;
				end else if (item_s1.offset == OFF_DATACTRL) begin
					res_n.read_data = {8'(fill_q), 24'b0} |
						((fill_q == '0) ? RD_RXEMPTY : 32'b0);
				end else if (item_s1.offset == OFF_RXB || item_s1.offset == OFF_RXH) begin
					// pos + fill never exceeds the depth, so a nonempty FIFO has pos in range
					if (fill_q != '0) begin
						res_n.read_data = {24'b0, fifo_q[pos_q[PIW-1:0]]};
						pos_n  = pos_q + 1'b1;
						fill_n = fill_q - 1'b1;
					end
				end else if (rd_word_ok) begin
					res_n.read_data = rdata_s1;
				end
			end
			KIND_WRITE: begin
				if (item_s1.offset == OFF_CTRL) begin
					status_n = status_n | ST_CTRLDONE;
					case (v[2:0])
						REQ_START: begin
							res_n.bus_cmd     = CMD_START;
							res_n.bus_is_i2c  = v[4];
							res_n.bus_read    = v[8];
							res_n.bus_addr    = v[15:9];
							res_n.read_length = v[8] ? rdterm : 8'd0;
							i2c_n = v[4];
							rem_n = '0;
							if (!item_s1.target_ack) begin
								err_n    = err_n | ERR_NACK;
								status_n = status_n | ST_NACKED;
							end else if (v[8]) begin
								fill_n = '0;
								pos_n  = '0;
								rem_n  = (9'(rdterm) < 9'(RX_DEPTH)) ? rdterm : 8'(RX_DEPTH);
								if (rdterm == 8'd0) begin
									status_n = status_n | ST_COMPLETE;
								end
							end
						end
						REQ_STOP: begin
							res_n.bus_cmd    = CMD_STOP;
							res_n.bus_is_i2c = i2c_q;
							rem_n = '0;
						end
						REQ_ASSIGN: begin
							// no targets on the bus: assignment finishes at once
							status_n = status_n | ST_COMPLETE;
						end
						default: begin
						end
					endcase
				end else if (item_s1.offset == OFF_TXB || item_s1.offset == OFF_TXH ||
						item_s1.offset == OFF_TXBE || item_s1.offset == OFF_TXHE) begin
					res_n.bus_cmd    = CMD_SEND;
					res_n.bus_is_i2c = i2c_q;
					res_n.bus_data   = v[7:0];
					if (item_s1.offset == OFF_TXBE || item_s1.offset == OFF_TXHE) begin
						status_n = status_n | ST_COMPLETE;
					end
				end else if (item_s1.offset == OFF_STATUS) begin
					status_n = status_q & ~v[ST_W-1:0];
				end else if (item_s1.offset == OFF_ERR) begin
					err_n = err_q & ~v[ERR_W-1:0];
				end else if (item_s1.offset == OFF_INTSET) begin
					irq_en_n = irq_en_q | v;
				end else if (item_s1.offset == OFF_INTCLR) begin
					irq_en_n = irq_en_q & ~v;
				end else if (item_s1.offset == OFF_DATACTRL) begin
					if (v[1]) begin
						fill_n = '0;
						pos_n  = '0;
					end
				end
			end
			KIND_BYTE: begin
				if (rem_q != 8'd0) begin
					if (push_idx < (CW + 1)'(RX_DEPTH)) begin
						fifo_we = 1'b1;
						fill_n  = fill_q + 1'b1;
					end
					rem_n = rem_q - 1'b1;
					if (rem_q == 8'd1) begin
						status_n = status_n | ST_COMPLETE;
					end
				end
			end
			KIND_END: begin
				if (rem_q != 8'd0) begin
					rem_n    = '0;
					status_n = status_n | ST_COMPLETE;
				end
			end
			default: begin
			end
		endcase

		masked    = ({21'b0, status_n} | ((err_n != '0) ? RD_ERRWARN : 32'b0)) & irq_en_n;
		res_n.irq = |masked;
	end

	always_ff @(posedge clk) begin
		if (adv && fifo_we) begin
			fifo_q[fifo_widx] <= item_s1.rx_byte;
		end
		if (adv) begin
			result_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			status_q       <= '0;
			err_q          <= '0;
			irq_en_q       <= '0;
			fill_q         <= '0;
			pos_q          <= '0;
			rem_q          <= '0;
			i2c_q          <= 1'b0;
		end else begin
			if (item_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (adv) begin
				status_q <= status_n;
				err_q    <= err_n;
				irq_en_q <= irq_en_n;
				fill_q   <= fill_n;
				pos_q    <= pos_n;
				rem_q    <= rem_n;
				i2c_q    <= i2c_n;
			end
		end
	end

	`FE_ASSERT_NOW(a_fifo_bound, 1'b1, ({1'b0, pos_q} + {1'b0, fill_q}) <= (CW + 1)'(RX_DEPTH), "receive FIFO position plus fill beyond depth")
	`FE_ASSERT_NEXT(a_idle_byte, adv && item_s1.kind == KIND_BYTE && rem_q == 8'd0, $stable(fill_q) && $stable(rem_q), "byte with no read pending changed FIFO state")
	`FE_ASSERT_NOW(a_clear_empty, clearing_q, !valid_s1 && !result_valid_q, "request in flight during scratch clearing pass")

endmodule
